/* src/bilinear_resize_normalize_top_macros.svh */
// assertion macros for the bilinear resize and normalize block
// used only by bilinear_resize_normalize_top, expects a clock and reset in scope
`ifndef BILINEAR_RESIZE_NORMALIZE_TOP_MACROS_SVH
`define BILINEAR_RESIZE_NORMALIZE_TOP_MACROS_SVH

// same-cycle implication
`define BRN_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BRN_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* src/brn_pkg.sv */
// shared types, constants and the normalization table builder
// used by brn_axis, brn_lane and bilinear_resize_normalize_top
package brn_pkg;

   localparam int MaxSrcDimDefault = 256;
   localparam int TargetDimDefault = 1024;
   localparam int NumChannels      = 3;

   localparam longint MeanRed   = 123675;
   localparam longint MeanGreen = 116280;
   localparam longint MeanBlue  = 103530;
   localparam longint StdRed    = 58395;
   localparam longint StdGreen  = 57120;
   localparam longint StdBlue   = 57375;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_SAMPLE = 1'b1
   } opcode_type;

   typedef enum logic {
      REG_SRC_WIDTH  = 1'b0,
      REG_SRC_HEIGHT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic mul1;
      logic mul2;
      logic load;
   } lane_ctrl_type;

   typedef logic signed [15:0] norm_lut_type [256];

   function automatic logic signed [15:0] norm_entry(int v, int ch);
      longint num;
      longint q;
      case (ch)
         0: begin
            num = (longint'(v) * 1000 - MeanRed) * 4096;
            if (num >= 0) q = (num + StdRed / 2) / StdRed;
            else q = -((-num + StdRed / 2) / StdRed);
         end
         1: begin
            num = (longint'(v) * 1000 - MeanGreen) * 4096;
            if (num >= 0) q = (num + StdGreen / 2) / StdGreen;
            else q = -((-num + StdGreen / 2) / StdGreen);
         end
         default: begin
            num = (longint'(v) * 1000 - MeanBlue) * 4096;
            if (num >= 0) q = (num + StdBlue / 2) / StdBlue;
            else q = -((-num + StdBlue / 2) / StdBlue);
         end
      endcase
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return 16'(q);
   endfunction

   function automatic norm_lut_type build_norm_lut(int ch);
      norm_lut_type lut;
      for (int v = 0; v < 256; v++) begin
         lut[v] = norm_entry(v, ch);
      end
      return lut;
   endfunction

endpackage

/* src/brn_axis.sv */
// maps one output coordinate to source base, neighbor and fraction with an arithmetic
// shift by clog2(2*TargetDim), registered on start; uses brn_pkg
module brn_axis #(
   parameter int MaxSrcDim = brn_pkg::MaxSrcDimDefault,
   parameter int TargetDim = brn_pkg::TargetDimDefault
) (
   input  logic                                     clock,
   input  logic                                     start,
   input  logic [9:0]                               coord,
   input  logic [$clog2(MaxSrcDim+1)-1:0]           span,
   input  logic [$clog2(MaxSrcDim+1)-1:0]           dim,
   output logic [$clog2(MaxSrcDim)-1:0]             base,
   output logic [$clog2(MaxSrcDim)-1:0]             nbr,
   output logic signed [$clog2(2*TargetDim):0]      frac
);
   localparam int AW = $clog2(MaxSrcDim);
   localparam int LF = $clog2(2*TargetDim);
   localparam int FW = LF + 1;
   localparam int XW = $clog2(2047*MaxSrcDim + 2*TargetDim*MaxSrcDim + 1) + 1;

   logic signed [XW-1:0] pos;
   logic signed [XW-1:0] quo;
   logic [AW-1:0]        dimm1;
   logic [AW-1:0]        base_ff, base_in, nbr_ff, nbr_in;
   logic signed [FW-1:0] frac_ff, frac_in;

   assign pos   = $signed(XW'({coord, 1'b1})) * $signed(XW'(span)) - $signed(XW'(TargetDim));
   assign quo   = pos >>> LF;
   assign dimm1 = AW'(dim - 1'b1);

   always_comb begin
      if (pos < 0) begin
         base_in = '0;
         frac_in = FW'(pos);
      end else if (quo >= $signed(XW'(dim))) begin
         base_in = dimm1;
         frac_in = '0;
      end else begin
         base_in = quo[AW-1:0];
         frac_in = $signed({1'b0, pos[LF-1:0]});
      end
      nbr_in = ({1'b0, base_in} + 1'b1 < {1'b0, dimm1}) ? AW'(base_in + 1'b1) : dimm1;
   end

   always_ff @(posedge clock) begin
      if (start) begin
         base_ff <= base_in;
         nbr_ff  <= nbr_in;
         frac_ff <= frac_in;
      end
   end

   assign base = base_ff;
   assign nbr  = nbr_ff;
   assign frac = frac_ff;

endmodule

/* src/brn_lane.sv */
// one color lane: bilinear weighting, rounding shift and normalization table
// uses brn_pkg for control struct and table builder
module brn_lane #(
   parameter int TargetDim = brn_pkg::TargetDimDefault,
   parameter int Channel   = 0
) (
   input  logic                                clock,
   input  brn_pkg::lane_ctrl_type              ctrl,
   input  logic [7:0]                          p00,
   input  logic [7:0]                          p01,
   input  logic [7:0]                          p10,
   input  logic [7:0]                          p11,
   input  logic signed [$clog2(2*TargetDim):0] dx,
   input  logic signed [$clog2(2*TargetDim):0] dy,
   output logic signed [15:0]                  norm
);
   localparam int     F      = 2 * TargetDim;
   localparam int     LF2    = 2 * $clog2(F);
   localparam int     WW     = $clog2(3*TargetDim + 1) + 1;
   localparam int     PW     = 9 + WW;
   localparam int     TW     = PW + 1;
   localparam int     MW     = TW + WW;
   localparam longint F2     = 4 * longint'(TargetDim) * TargetDim;
   localparam longint NumMax = 4080 * longint'(TargetDim) * TargetDim;
   localparam int     NW     = $clog2(NumMax) + 2;
   localparam logic signed [NW-1:0] HalfF2 = NW'(F2 / 2);
   localparam logic signed [NW-1:0] SatLim = NW'(F2 * 256);
   localparam brn_pkg::norm_lut_type NormLut = brn_pkg::build_norm_lut(Channel);

   logic signed [WW-1:0] wx0, wx1, wy0, wy1;
   logic signed [PW-1:0] a_ff, b_ff, c_ff, d_ff;
   logic signed [PW-1:0] a_in, b_in, c_in, d_in;
   logic signed [TW-1:0] top, bot;
   logic signed [MW-1:0] m1_ff, m2_ff, m1_in, m2_in;
   logic signed [NW-1:0] num, rnd;
   logic [7:0]           v_ff, v_in;

   assign wx0 = WW'(F) - WW'(dx);
   assign wx1 = WW'(dx);
   assign wy0 = WW'(F) - WW'(dy);
   assign wy1 = WW'(dy);

   assign a_in = $signed({1'b0, p00}) * wx0;
   assign b_in = $signed({1'b0, p01}) * wx1;
   assign c_in = $signed({1'b0, p10}) * wx0;
   assign d_in = $signed({1'b0, p11}) * wx1;

   assign top = TW'(a_ff) + TW'(b_ff);
   assign bot = TW'(c_ff) + TW'(d_ff);
   assign m1_in = top * wy0;
   assign m2_in = bot * wy1;

   assign num  = NW'(m1_ff) + NW'(m2_ff);
   assign rnd  = num + HalfF2;
   assign v_in = (num <= 0) ? 8'd0 : (rnd >= SatLim) ? 8'd255 : rnd[LF2 +: 8];

   always_ff @(posedge clock) begin
      if (ctrl.mul1) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
         d_ff <= d_in;
      end
      if (ctrl.mul2) begin
         m1_ff <= m1_in;
         m2_ff <= m2_in;
      end
      if (ctrl.load) begin
         v_ff <= v_in;
      end
   end

   assign norm = NormLut[v_ff];

endmodule

/* src/bilinear_resize_normalize_top.sv */
// bilinear resize and normalize: sequencer, image store, three lanes, result register
// a load writes the store at the accepting edge; a sample item keeps busy high through
// four single-port store reads, the read register, two multiply stages, rounding and output
// the result strobe follows in the next cycle, as busy falls
// samples and loads are taken only while idle, one load per cycle; the receiver cannot stall
// reset returns the sequencer to idle and width and height to 256; store content is kept
module bilinear_resize_normalize_top #(
   parameter int MaxSrcDim = brn_pkg::MaxSrcDimDefault,
   parameter int TargetDim = brn_pkg::TargetDimDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_opcode,
   input  logic [7:0]         req_load_x,
   input  logic [7:0]         req_load_y,
   input  logic [7:0]         req_pixel_red,
   input  logic [7:0]         req_pixel_green,
   input  logic [7:0]         req_pixel_blue,
   input  logic [9:0]         req_out_x,
   input  logic [9:0]         req_out_y,
   output logic               rsp_strobe,
   output logic signed [15:0] rsp_norm_red,
   output logic signed [15:0] rsp_norm_green,
   output logic signed [15:0] rsp_norm_blue,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   `include "bilinear_resize_normalize_top_macros.svh"

   localparam int AW    = $clog2(MaxSrcDim);
   localparam int DW    = $clog2(MaxSrcDim + 1);
   localparam int FW    = $clog2(2*TargetDim) + 1;
   localparam int Depth = MaxSrcDim * MaxSrcDim;
   localparam int MAW   = $clog2(Depth);
   localparam int CntW  = 3;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_RD   = 6'b000010,
      ST_MUL1 = 6'b000100,
      ST_MUL2 = 6'b001000,
      ST_RND  = 6'b010000,
      ST_FIN  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [8:0] src_width_ff, src_height_ff;
   logic strobe_ff;
   logic signed [15:0] red_ff, green_ff, blue_ff;

   logic accept, do_sample, do_load, csr_write, mem_we, axis_start;
   logic [DW-1:0] eff_w, eff_h, span;
   logic [MAW-1:0] mem_addr, wr_addr;
   logic [MAW-1:0] rd_addr [4];
   logic [23:0] store [Depth];
   logic [23:0] rdata_ff;
   logic [23:0] pix_ff [4];
   logic [AW-1:0] x0, x1, y0, y1;
   logic signed [FW-1:0] dx, dy;
   logic signed [15:0] lane_norm [brn_pkg::NumChannels];
   brn_pkg::lane_ctrl_type lane_ctrl;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign do_sample = accept && (req_opcode == brn_pkg::OP_SAMPLE);
   assign do_load   = accept && (req_opcode == brn_pkg::OP_LOAD);
   assign mem_we    = do_load && (32'(req_load_x) < MaxSrcDim) && (32'(req_load_y) < MaxSrcDim);

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == brn_pkg::REG_SRC_HEIGHT) ? {23'd0, src_height_ff}
                                                             : {23'd0, src_width_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= 9'd256;
         src_height_ff <= 9'd256;
      end else if (csr_write) begin
         if (paddr[2] == brn_pkg::REG_SRC_HEIGHT) src_height_ff <= pwdata[8:0];
         else src_width_ff <= pwdata[8:0];
      end
   end

   assign eff_w = (src_width_ff == 9'd0) ? DW'(1) :
                  (32'(src_width_ff) > MaxSrcDim) ? DW'(MaxSrcDim) : DW'(src_width_ff);
   assign eff_h = (src_height_ff == 9'd0) ? DW'(1) :
                  (32'(src_height_ff) > MaxSrcDim) ? DW'(MaxSrcDim) : DW'(src_height_ff);
   assign span  = (eff_w > eff_h) ? eff_w : eff_h;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff + 1'b1;
      axis_start = 1'b0;
      lane_ctrl  = '0;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (do_sample) begin
               axis_start = 1'b1;
               state_in   = ST_RD;
            end
         end
         ST_RD: begin
            if (cnt_ff == CntW'(4)) begin
               cnt_in   = '0;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            lane_ctrl.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            lane_ctrl.mul2 = 1'b1;
            state_in = ST_RND;
         end
         ST_RND: begin
            lane_ctrl.load = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         strobe_ff <= (state_ff == ST_FIN);
      end
   end

   brn_axis #(.MaxSrcDim(MaxSrcDim), .TargetDim(TargetDim)) u_axis_x (
      .clock(clock), .start(axis_start), .coord(req_out_x), .span(span), .dim(eff_w),
      .base(x0), .nbr(x1), .frac(dx)
   );

   brn_axis #(.MaxSrcDim(MaxSrcDim), .TargetDim(TargetDim)) u_axis_y (
      .clock(clock), .start(axis_start), .coord(req_out_y), .span(span), .dim(eff_h),
      .base(y0), .nbr(y1), .frac(dy)
   );

   // image store, single port
   assign wr_addr    = MAW'(32'(req_load_y) * MaxSrcDim + 32'(req_load_x));
   assign rd_addr[0] = MAW'(32'(y0) * MaxSrcDim + 32'(x0));
   assign rd_addr[1] = MAW'(32'(y0) * MaxSrcDim + 32'(x1));
   assign rd_addr[2] = MAW'(32'(y1) * MaxSrcDim + 32'(x0));
   assign rd_addr[3] = MAW'(32'(y1) * MaxSrcDim + 32'(x1));
   assign mem_addr   = (state_ff == ST_RD) ? rd_addr[cnt_ff[1:0]] : wr_addr;

   always_ff @(posedge clock) begin
      if (mem_we) store[mem_addr] <= {req_pixel_blue, req_pixel_green, req_pixel_red};
      rdata_ff <= store[mem_addr];
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_RD) && (cnt_ff != '0)) pix_ff[2'(cnt_ff - 1'b1)] <= rdata_ff;
   end

   for (genvar c = 0; c < brn_pkg::NumChannels; c++) begin : g_lane
      brn_lane #(.TargetDim(TargetDim), .Channel(c)) u_lane (
         .clock(clock), .ctrl(lane_ctrl),
         .p00(pix_ff[0][8*c +: 8]), .p01(pix_ff[1][8*c +: 8]),
         .p10(pix_ff[2][8*c +: 8]), .p11(pix_ff[3][8*c +: 8]),
         .dx(dx), .dy(dy), .norm(lane_norm[c])
      );
   end

   // result register across the lanes
   always_ff @(posedge clock) begin
      if (state_ff == ST_FIN) begin
         red_ff   <= lane_norm[0];
         green_ff <= lane_norm[1];
         blue_ff  <= lane_norm[2];
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_norm_red   = red_ff;
   assign rsp_norm_green = green_ff;
   assign rsp_norm_blue  = blue_ff;

   `BRN_ASSERT_NEXT(a_strobe_after_fin, state_ff == ST_FIN, rsp_strobe, "strobe missing after finish")
   `BRN_ASSERT_NOW(a_strobe_idle, rsp_strobe, !busy && $past(state_ff == ST_FIN), "stray strobe")
   `BRN_ASSERT_NEXT(a_sample_busy, do_sample, busy && !rsp_strobe, "sample did not start")
   `BRN_ASSERT_NOW(a_no_write_busy, busy, !mem_we, "store written while busy")

endmodule
